/* sv/tvp_pkg.sv */
`default_nettype none
package tvp_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int REG_BITS  = WORD_BITS - 1;
  localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int RAD_BITS  = 2 * REG_BITS;
  localparam int REM_BITS  = WORD_BITS + 2;
  localparam int CNT_BITS  = $clog2(QUO_BITS + 1);

  localparam logic [WORD_BITS-1:0] MAG_MAX  = {1'b0, {REG_BITS{1'b1}}};
  localparam logic [WORD_BITS-1:0] TIME_MAX = {WORD_BITS{1'b1}};

  localparam logic [REG_BITS-1:0] VMAX_RESET = REG_BITS'(131072);
  localparam logic [REG_BITS-1:0] AMAX_RESET = REG_BITS'(65536);

  localparam logic [1:0] CFG_VEL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MAX_ACCEL = 2'd1;

  localparam logic OP_PLAN   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                        op;
    logic signed [WORD_BITS-1:0] start_position;
    logic signed [WORD_BITS-1:0] end_position;
    logic [WORD_BITS-1:0]        elapsed;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] velocity;
    logic [WORD_BITS-1:0]        duration;
    logic                        triangular;
    logic                        in_motion;
  } out_item_t;

  // command to the shared divide / square root unit
  typedef struct packed {
    logic                 start;
    logic                 is_sqrt;
    logic                 lim_time;
    logic [WORD_BITS-1:0] num;
    logic [WORD_BITS-1:0] den;
    logic [RAD_BITS-1:0]  rad;
  } iter_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] result;
  } iter_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN_MAG,
    S_PLAN_VV,
    S_PLAN_RAMP,
    S_PLAN_SHAPE,
    S_PLAN_ROOT,
    S_PLAN_ROOT_WAIT,
    S_PLAN_ACCEL,
    S_PLAN_CRUISE,
    S_PLAN_SUM1,
    S_PLAN_SUM2,
    S_SMP_MUL,
    S_SMP_VEL,
    S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_CRUISE,
    SEG_FALL
  } seg_t;

endpackage
`default_nettype wire

/* sv/tvp_iter_unit.sv */
`default_nettype none
module tvp_iter_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  tvp_pkg::iter_cmd_t cmd,
  output tvp_pkg::iter_rsp_t rsp
);
  import tvp_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 is_sqrt_r;
  logic                 lim_time_r;
  logic [REM_BITS-1:0]  rem_r;
  logic [QUO_BITS-1:0]  q_r;
  logic [PROD_BITS-1:0] src_r;
  logic [WORD_BITS-1:0] den_r;

  logic [REM_BITS-1:0]  shifted;
  logic [REM_BITS-1:0]  trial;
  logic                 ge;
  logic [WORD_BITS-1:0] lim;

  // one restoring step: bring down one dividend bit or one radicand pair
  always_comb begin
    if (is_sqrt_r) begin
      shifted = {rem_r[REM_BITS-3:0], src_r[PROD_BITS-1 -: 2]};
      trial   = {q_r[REM_BITS-3:0], 2'b01};
    end else begin
      shifted = {rem_r[REM_BITS-2:0], src_r[PROD_BITS-1]};
      trial   = {2'b00, den_r};
    end
    ge  = (shifted >= trial);
    lim = lim_time_r ? TIME_MAX : MAG_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r     <= 1'b1;
        is_sqrt_r  <= cmd.is_sqrt;
        lim_time_r <= cmd.lim_time;
        den_r      <= cmd.den;
        rem_r      <= '0;
        q_r        <= '0;
        if (cmd.is_sqrt) begin
          src_r <= {cmd.rad, 2'b00};
          cnt_r <= CNT_BITS'(REG_BITS);
        end else begin
          src_r <= {cmd.num, {(PROD_BITS-WORD_BITS){1'b0}}};
          cnt_r <= CNT_BITS'(QUO_BITS);
        end
      end else if (busy_r) begin
        rem_r <= ge ? (shifted - trial) : shifted;
        q_r   <= {q_r[QUO_BITS-2:0], ge};
        src_r <= is_sqrt_r ? {src_r[PROD_BITS-3:0], 2'b00} : {src_r[PROD_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // saturate quotient; a zero divisor gives all ones and lands on the limit
  always_comb begin
    rsp.done = done_r;
    if (is_sqrt_r) begin
      rsp.result = q_r[WORD_BITS-1:0];
    end else if (q_r > {{(QUO_BITS-WORD_BITS){1'b0}}, lim}) begin
      rsp.result = lim;
    end else begin
      rsp.result = q_r[WORD_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

/* sv/trapezoid_velocity_profile_top.sv */
`default_nettype none
// Trapezoidal velocity profile generator.
// Input channel (in_valid / in_stall / in_item): op 0 plans a move from
// start_position to end_position; op 1 samples the stored profile at elapsed.
// Output channel (out_valid / out_stall / out_item): one transaction per input,
// carrying velocity, total duration, shape flag and in_motion.
// Configuration (cfg_we / cfg_index / cfg_wdata): index 0 velocity limit,
// index 1 max_accel; write only while idle.
// A sample passes S_SMP_MUL, S_SMP_VEL and S_OUT before it reaches the output
// register. A plan runs three 48-step divisions when trapezoidal, or two
// divisions plus a 31-step square root when triangular, on the single shared
// divide / square root unit.
// in_stall is high for the whole item.
// Results sit in an output register; a stalled receiver holds it, and the
// sequencer waits with the next result until that register is free.
// Reset (synchronous, rst_n low) restores a velocity limit of 2.0, max_accel
// 1.0 and an empty zero-duration plan, so samples then return zero velocity.
module trapezoid_velocity_profile_top (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  tvp_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output tvp_pkg::out_item_t   out_item,
  input  wire                  cfg_we,
  input  wire [1:0]            cfg_index,
  input  wire [30:0]           cfg_wdata
);
  import tvp_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [REG_BITS-1:0]  vmax_r;
  logic [REG_BITS-1:0]  amax_r;
  in_item_t             item_r;
  logic                 dir_neg_r;
  logic                 tri_r;
  logic [WORD_BITS-1:0] ramp_time_r;
  logic [WORD_BITS-1:0] cruise_end_r;
  logic [WORD_BITS-1:0] total_r;
  logic [WORD_BITS-1:0] peak_r;
  logic [WORD_BITS-1:0] plan_accel_r;
  logic [WORD_BITS-1:0] mag_r;
  logic [WORD_BITS-1:0] two_ramp_r;
  logic [PROD_BITS-1:0] prod_r;
  seg_t                 seg_r;
  logic                 moving_r;
  logic [WORD_BITS-1:0] vel_r;
  out_item_t            out_r;
  logic                 out_valid_r;

  iter_cmd_t            cmd;
  iter_rsp_t            rsp;
  logic [WORD_BITS-1:0] mul_a, mul_b;

  logic signed [WORD_BITS:0] diff;
  logic [WORD_BITS:0]        diff_abs;
  logic [WORD_BITS-1:0]      mag_sat;
  logic [WORD_BITS-1:0]      prod_sat;
  logic [WORD_BITS:0]        ramp2;
  logic [WORD_BITS:0]        sum_end;
  logic [WORD_BITS:0]        sum_total;
  logic signed [WORD_BITS:0] speed;
  logic signed [WORD_BITS:0] speed_dir;
  logic [WORD_BITS-1:0]      t_smp;

  tvp_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  // shared datapath terms
  always_comb begin
    diff      = $signed({item_r.end_position[WORD_BITS-1], item_r.end_position})
              - $signed({item_r.start_position[WORD_BITS-1], item_r.start_position});
    diff_abs  = diff[WORD_BITS] ? (~diff + (WORD_BITS+1)'(1)) : diff;
    mag_sat   = (diff_abs > {1'b0, MAG_MAX}) ? MAG_MAX : diff_abs[WORD_BITS-1:0];
    prod_sat  = (prod_r[PROD_BITS-1:FRAC_BITS] > {{(PROD_BITS-FRAC_BITS-WORD_BITS){1'b0}}, MAG_MAX})
              ? MAG_MAX : prod_r[FRAC_BITS +: WORD_BITS];
    ramp2     = {1'b0, rsp.result} + {1'b0, rsp.result};
    sum_end   = {1'b0, ramp_time_r} + {1'b0, cruise_end_r};
    sum_total = {1'b0, cruise_end_r} + {1'b0, ramp_time_r};
    t_smp     = item_r.elapsed;
    unique case (seg_r)
      SEG_RISE:   speed = $signed({1'b0, prod_sat});
      SEG_CRUISE: speed = $signed({1'b0, peak_r});
      default:    speed = $signed({1'b0, peak_r}) - $signed({1'b0, prod_sat});
    endcase
    speed_dir = dir_neg_r ? -speed : speed;
  end

  // multiplier operand select
  always_comb begin
    mul_a = {1'b0, vmax_r};
    mul_b = {1'b0, vmax_r};
    unique case (state_r)
      S_PLAN_SHAPE: begin
        mul_a = mag_r;
        mul_b = {1'b0, amax_r};
      end
      S_SMP_MUL: begin
        mul_a = plan_accel_r;
        mul_b = (t_smp < ramp_time_r) ? t_smp : (t_smp - cruise_end_r);
      end
      default: begin
        mul_a = {1'b0, vmax_r};
        mul_b = {1'b0, vmax_r};
      end
    endcase
  end

  // next state and unit commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_item.op == OP_SAMPLE) ? S_SMP_MUL : S_PLAN_MAG;
        end
      end
      S_PLAN_MAG: state_nxt = S_PLAN_VV;
      S_PLAN_VV: begin
        cmd.start = 1'b1;
        cmd.num   = prod_sat;
        cmd.den   = {amax_r, 1'b0};
        state_nxt = S_PLAN_RAMP;
      end
      S_PLAN_RAMP: begin
        if (rsp.done) begin
          state_nxt = S_PLAN_SHAPE;
        end
      end
      S_PLAN_SHAPE: begin
        if (mag_r >= two_ramp_r) begin
          cmd.start    = 1'b1;
          cmd.lim_time = 1'b1;
          cmd.num      = {1'b0, vmax_r};
          cmd.den      = {1'b0, amax_r};
          state_nxt    = S_PLAN_ACCEL;
        end else begin
          state_nxt = S_PLAN_ROOT;
        end
      end
      S_PLAN_ROOT: begin
        cmd.start   = 1'b1;
        cmd.is_sqrt = 1'b1;
        cmd.rad     = prod_r[RAD_BITS-1:0];
        state_nxt   = S_PLAN_ROOT_WAIT;
      end
      S_PLAN_ROOT_WAIT: begin
        if (rsp.done) begin
          cmd.start    = 1'b1;
          cmd.lim_time = 1'b1;
          cmd.num      = rsp.result;
          cmd.den      = {1'b0, amax_r};
          state_nxt    = S_PLAN_ACCEL;
        end
      end
      S_PLAN_ACCEL: begin
        if (rsp.done) begin
          if (!tri_r) begin
            cmd.start    = 1'b1;
            cmd.lim_time = 1'b1;
            cmd.num      = mag_r - two_ramp_r;
            cmd.den      = {1'b0, vmax_r};
            state_nxt    = S_PLAN_CRUISE;
          end else begin
            state_nxt = S_PLAN_SUM1;
          end
        end
      end
      S_PLAN_CRUISE: begin
        if (rsp.done) begin
          state_nxt = S_PLAN_SUM1;
        end
      end
      S_PLAN_SUM1: state_nxt = S_PLAN_SUM2;
      S_PLAN_SUM2: state_nxt = S_OUT;
      S_SMP_MUL:   state_nxt = S_SMP_VEL;
      S_SMP_VEL:   state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vmax_r <= VMAX_RESET;
      amax_r <= AMAX_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_VEL_LIMIT) begin
        vmax_r <= cfg_wdata;
      end else if (cfg_index == CFG_MAX_ACCEL) begin
        amax_r <= cfg_wdata;
      end
    end
  end

  // plan state and working registers
  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    if (!rst_n) begin
      dir_neg_r    <= 1'b0;
      tri_r        <= 1'b0;
      ramp_time_r  <= '0;
      cruise_end_r <= '0;
      total_r      <= '0;
      peak_r       <= '0;
      plan_accel_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_item;
          end
        end
        S_PLAN_MAG: begin
          mag_r     <= mag_sat;
          dir_neg_r <= !(item_r.end_position > item_r.start_position);
        end
        S_PLAN_RAMP: begin
          if (rsp.done) begin
            two_ramp_r <= (ramp2 > {1'b0, MAG_MAX}) ? MAG_MAX : ramp2[WORD_BITS-1:0];
          end
        end
        S_PLAN_SHAPE: begin
          if (mag_r >= two_ramp_r) begin
            tri_r  <= 1'b0;
            peak_r <= {1'b0, vmax_r};
          end else begin
            tri_r <= 1'b1;
          end
        end
        S_PLAN_ROOT_WAIT: begin
          if (rsp.done) begin
            peak_r <= rsp.result;
          end
        end
        S_PLAN_ACCEL: begin
          if (rsp.done) begin
            ramp_time_r  <= rsp.result;
            cruise_end_r <= '0;
          end
        end
        S_PLAN_CRUISE: begin
          if (rsp.done) begin
            cruise_end_r <= rsp.result;
          end
        end
        S_PLAN_SUM1: begin
          cruise_end_r <= sum_end[WORD_BITS] ? TIME_MAX : sum_end[WORD_BITS-1:0];
        end
        S_PLAN_SUM2: begin
          total_r      <= sum_total[WORD_BITS] ? TIME_MAX : sum_total[WORD_BITS-1:0];
          plan_accel_r <= {1'b0, amax_r};
          vel_r        <= '0;
          moving_r     <= 1'b0;
        end
        S_SMP_MUL: begin
          moving_r <= (t_smp != '0) && (t_smp < total_r);
          if (t_smp < ramp_time_r) begin
            seg_r <= SEG_RISE;
          end else if (t_smp < cruise_end_r) begin
            seg_r <= SEG_CRUISE;
          end else begin
            seg_r <= SEG_FALL;
          end
        end
        S_SMP_VEL: begin
          vel_r <= moving_r ? speed_dir[WORD_BITS-1:0] : '0;
        end
        default: begin
        end
      endcase
    end
  end

  // output register: load when free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r      <= 1'b1;
        out_r.velocity   <= vel_r;
        out_r.duration   <= total_r;
        out_r.triangular <= tri_r;
        out_r.in_motion  <= moving_r;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire
